// ----- rtl/acoustic_wave_stencil_step_defines.svh -----
// assertion macros shared by the wave stencil checker
`ifndef ACOUSTIC_WAVE_STENCIL_STEP_DEFINES_SVH
`define ACOUSTIC_WAVE_STENCIL_STEP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define AWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define AWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/awstep_pkg.sv -----
// shared constants and types for the acoustic wave stencil step
package awstep_pkg;

    localparam int unsigned DEF_MAX_DEPTH = 1024;
    localparam int unsigned DEF_MAX_WIDTH = 4096;
    localparam int unsigned MIN_DIM       = 5;

    localparam int unsigned FIELD_W = 24;
    localparam int unsigned VEL_W   = 16;
    localparam int unsigned ILL_W   = 32;

    // line memory word: four field lanes, two lanes each of prev, velocity, illum
    localparam int unsigned FLD_OFS  = 0;
    localparam int unsigned PREV_OFS = 4 * FIELD_W;
    localparam int unsigned VEL_OFS  = PREV_OFS + 2 * FIELD_W;
    localparam int unsigned ILL_OFS  = VEL_OFS + 2 * VEL_W;
    localparam int unsigned WORD_W   = ILL_OFS + 2 * ILL_W;

    localparam int unsigned IN_TDATA_W  = 96;
    localparam int unsigned OUT_TDATA_W = 104;
    localparam int unsigned OUT_COL_LSB = 80;
    localparam int unsigned OUT_ROW_LSB = 92;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 48;

    localparam logic signed [23:0] Q24_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] Q24_MIN = 24'sh800000;
    localparam logic [26:0]        TERM_LIM = 27'h4000000;
    localparam logic [31:0]        RECIP3   = 32'hAAAAAAAB;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BACKWARD_MODE = 3'd0,
        REG_INV_DX2       = 3'd1,
        REG_INV_DZ2       = 3'd2,
        REG_DT2           = 3'd3,
        REG_GRID_DEPTH    = 3'd4,
        REG_GRID_WIDTH    = 3'd5
    } cfg_reg_t;

endpackage

// ----- rtl/acoustic_wave_stencil_step.sv -----
// fourth-order acoustic wave stencil step over a column-major padded grid
//
//  channel | direction | accepted when            | carries
//  s_*     | in        | s_tvalid & s_tready      | one grid cell, tuser = frame start
//  m_*     | out       | m_tvalid & m_tready      | one interior result, tlast = frame end
//  cfg_*   | in        | cfg_valid & cfg_ready    | register index and write data
//
// takes one cell per clock while no result is stalled; each result passes through the
// multiply chain behind the line memory read
// the line memory reads two rows ahead so the vertical taps are ready in order
// a stalled result holds the whole pipe, and with it s_tready
// reset clears position and registers; the line memory is not cleared
module acoustic_wave_stencil_step #(
    parameter int unsigned MAX_DEPTH = awstep_pkg::DEF_MAX_DEPTH,
    parameter int unsigned MAX_WIDTH = awstep_pkg::DEF_MAX_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cur_field[23:0], prev_field[47:24], velocity[63:48], illum_in[95:64]
    input  logic [awstep_pkg::IN_TDATA_W-1:0]   s_tdata,
    // frame_start[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // new_prev[23:0], lap_out[47:24], illum_out[79:48], out_col[91:80],
    // out_row[101:92], zero[103:102]
    output logic [awstep_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [awstep_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [awstep_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import awstep_pkg::*;

    localparam int unsigned ROW_W = $clog2(MAX_DEPTH);
    localparam int unsigned COL_W = $clog2(MAX_WIDTH);

    typedef struct packed {
        logic signed [23:0] u;
        logic signed [23:0] ub;
        logic [31:0]        il;
        logic signed [23:0] lap;
        logic [79:0]        vd;
        logic [11:0]        col;
        logic [9:0]         row;
        logic               last;
    } ctx_t;

    function automatic logic signed [23:0] fld_lane(input logic [WORD_W-1:0] w,
                                                    input logic [1:0] k);
        fld_lane = w[FLD_OFS + 32'(k) * FIELD_W +: FIELD_W];
    endfunction

    // configuration
    logic        backward_mode_reg;
    logic [31:0] inv_dx2_reg;
    logic [31:0] inv_dz2_reg;
    logic [47:0] dt2_reg;
    logic [10:0] grid_depth_reg;
    logic [12:0] grid_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            backward_mode_reg <= 1'b0;
            inv_dx2_reg       <= '0;
            inv_dz2_reg       <= '0;
            dt2_reg           <= '0;
            grid_depth_reg    <= 11'd1024;
            grid_width_reg    <= 13'd4096;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_BACKWARD_MODE: backward_mode_reg <= cfg_data[0];
                REG_INV_DX2:       inv_dx2_reg       <= cfg_data[31:0];
                REG_INV_DZ2:       inv_dz2_reg       <= cfg_data[31:0];
                REG_DT2:           dt2_reg           <= cfg_data[47:0];
                REG_GRID_DEPTH:    grid_depth_reg    <= cfg_data[10:0];
                REG_GRID_WIDTH:    grid_width_reg    <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // geometry clamp
    logic [31:0]    gd32;
    logic [31:0]    gw32;
    logic [ROW_W:0] depth_c;
    logic [COL_W:0] width_c;

    always_comb begin
        gd32 = 32'(grid_depth_reg);
        gw32 = 32'(grid_width_reg);
        priority if (gd32 < MIN_DIM) gd32 = MIN_DIM;
        else if (gd32 > MAX_DEPTH)   gd32 = MAX_DEPTH;
        priority if (gw32 < MIN_DIM) gw32 = MIN_DIM;
        else if (gw32 > MAX_WIDTH)   gw32 = MAX_WIDTH;
        depth_c = (ROW_W + 1)'(gd32);
        width_c = (COL_W + 1)'(gw32);
    end

    // handshake
    logic m_tvalid_reg;
    logic adv;
    logic acc;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign acc      = s_tvalid && adv;

    // position
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [COL_W:0]   col_p1;
    logic [ROW_W:0]   row_p1;
    logic [ROW_W:0]   row_p3;
    logic [ROW_W:0]   ra_ext;
    logic [ROW_W-1:0] rd_addr;
    logic             interior;
    logic             frame_last;

    always_comb begin
        col_cur = s_tuser ? '0 : col_cnt_reg;
        row_cur = s_tuser ? '0 : row_cnt_reg;
        col_p1  = {1'b0, col_cur} + (COL_W + 1)'(1);
        row_p1  = {1'b0, row_cur} + (ROW_W + 1)'(1);
        row_p3  = {1'b0, row_cur} + (ROW_W + 1)'(3);
        if (row_p1 >= depth_c) begin
            row_cnt_next = '0;
            col_cnt_next = (col_p1 >= width_c) ? '0 : col_p1[COL_W-1:0];
        end else begin
            row_cnt_next = row_p1[ROW_W-1:0];
            col_cnt_next = ({1'b0, col_cur} >= width_c) ? '0 : col_cur;
        end
        // read two rows ahead, wrapping into the next column
        ra_ext = {1'b0, row_cur} + (ROW_W + 1)'(2);
        if (ra_ext >= depth_c) ra_ext = ra_ext - depth_c;
        rd_addr    = ra_ext[ROW_W-1:0];
        interior   = (col_cur >= COL_W'(4)) && ({1'b0, col_cur} < width_c)
                     && (row_cur >= ROW_W'(2)) && (row_p3 <= depth_c);
        frame_last = (col_p1 == width_c) && (row_p3 == depth_c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (acc) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // line memory with lane writes and a read-ahead window
    logic [WORD_W-1:0] mem [MAX_DEPTH];
    logic [WORD_W-1:0] rdata_reg;
    logic [WORD_W-1:0] win_reg [4];
    logic [1:0]        wr_lane;
    logic              wr_dl;

    assign wr_lane = col_cur[1:0];
    assign wr_dl   = col_cur[0];

    always_ff @(posedge aclk) begin
        if (acc) begin
            mem[row_cur][FLD_OFS + 32'(wr_lane) * FIELD_W +: FIELD_W] <= s_tdata[23:0];
            mem[row_cur][PREV_OFS + 32'(wr_dl) * FIELD_W +: FIELD_W]  <= s_tdata[47:24];
            mem[row_cur][VEL_OFS + 32'(wr_dl) * VEL_W +: VEL_W]       <= s_tdata[63:48];
            mem[row_cur][ILL_OFS + 32'(wr_dl) * ILL_W +: ILL_W]       <= s_tdata[95:64];
            rdata_reg  <= mem[rd_addr];
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= win_reg[3];
            win_reg[3] <= rdata_reg;
        end
    end

    // pipeline valid bits
    logic vld_reg [9];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) vld_reg[i] <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= acc && interior;
            for (int i = 1; i < 9; i++) vld_reg[i] <= vld_reg[i-1];
            m_tvalid_reg <= vld_reg[8];
        end
    end

    // stage 0: accepted cell
    logic signed [23:0] s0_cur_reg;
    logic [1:0]         s0_lane_reg;
    logic               s0_dl_reg;
    logic [11:0]        s0_col_reg;
    logic [9:0]         s0_row_reg;
    logic               s0_last_reg;

    // stage 1: taps
    logic [1:0]         sc_lane, sm_lane, sp_lane;
    logic signed [23:0] u_c;
    logic signed [30:0] lx_next, lz_next;
    logic signed [30:0] lx_reg, lz_reg;
    logic [15:0]        vel1_reg;
    ctx_t               ctx1_next;
    ctx_t               ctx_reg [1:8];

    always_comb begin
        sc_lane = s0_lane_reg + 2'd2;
        sm_lane = s0_lane_reg + 2'd1;
        sp_lane = s0_lane_reg + 2'd3;
        u_c     = fld_lane(win_reg[2], sc_lane);
        lx_next = 31'(-30) * 31'(u_c)
                  + 31'(16) * (31'(fld_lane(win_reg[2], sm_lane))
                               + 31'(fld_lane(win_reg[2], sp_lane)))
                  - (31'(fld_lane(win_reg[2], s0_lane_reg)) + 31'(s0_cur_reg));
        lz_next = 31'(-30) * 31'(u_c)
                  + 31'(16) * (31'(fld_lane(win_reg[1], sc_lane))
                               + 31'(fld_lane(win_reg[3], sc_lane)))
                  - (31'(fld_lane(win_reg[0], sc_lane))
                     + 31'(fld_lane(rdata_reg, sc_lane)));
        ctx1_next      = '0;
        ctx1_next.u    = u_c;
        ctx1_next.ub   = win_reg[2][PREV_OFS + 32'(s0_dl_reg) * FIELD_W +: FIELD_W];
        ctx1_next.il   = win_reg[2][ILL_OFS + 32'(s0_dl_reg) * ILL_W +: ILL_W];
        ctx1_next.col  = s0_col_reg;
        ctx1_next.row  = s0_row_reg;
        ctx1_next.last = s0_last_reg;
    end

    // stage 2 to 8 arithmetic
    logic signed [63:0] px_reg, pz_reg;
    logic [46:0]        usq_reg;
    logic [31:0]        vsq_reg;
    logic signed [47:0] usq_full;

    logic signed [63:0] sum_reg;
    logic [55:0]        pvd_lo_reg, pvd_hi_reg;
    logic [30:0]        sq_c;
    logic [32:0]        ilsum_c;
    logic [31:0]        ill_next;

    logic [63:0]        abs_c;
    logic [63:0]        rnd_c;
    logic [29:0]        n_reg;
    logic               neg4_reg, neg5_reg;

    logic [61:0]        qprod_c;
    logic [28:0]        q_reg;
    logic signed [23:0] lap_next;

    logic [23:0]        mag_c;
    logic [50:0]        pp0_reg, pp1_reg;
    logic [49:0]        pp2_reg;
    logic [103:0]       total_reg;

    always_comb begin
        usq_full = ctx_reg[1].u * ctx_reg[1].u;
        sq_c     = 31'((usq_reg + 47'h8000) >> 16);
        ilsum_c  = 33'(ctx_reg[2].il) + 33'(sq_c);
        if (backward_mode_reg) begin
            ill_next = ilsum_c[32] ? 32'hFFFFFFFF : ilsum_c[31:0];
        end else begin
            ill_next = ctx_reg[2].il;
        end
        abs_c   = sum_reg[63] ? 64'(-sum_reg) : 64'(sum_reg);
        rnd_c   = abs_c + (64'(6) << 32);
        // divide by three through a reciprocal
        qprod_c = 62'(n_reg) * 62'(RECIP3);
        if (neg5_reg) begin
            lap_next = (q_reg > 29'd8388608) ? Q24_MIN : -24'(q_reg);
        end else begin
            lap_next = (q_reg > 29'(Q24_MAX)) ? Q24_MAX : 24'(q_reg);
        end
        mag_c = ctx_reg[6].lap[23] ? 24'(-ctx_reg[6].lap) : 24'(ctx_reg[6].lap);
    end

    // stage 9: clamp wave term and form the result
    logic [55:0]        r_c;
    logic [26:0]        term_c;
    logic signed [28:0] sterm_c;
    logic signed [28:0] np_c;
    logic signed [23:0] np_next;
    logic signed [23:0] lap_o;

    always_comb begin
        r_c     = total_reg[103:48];
        term_c  = (r_c > 56'(TERM_LIM)) ? TERM_LIM : r_c[26:0];
        sterm_c = ctx_reg[8].lap[23] ? -$signed(29'(term_c)) : $signed(29'(term_c));
        np_c    = (29'(ctx_reg[8].u) <<< 1) - 29'(ctx_reg[8].ub) + sterm_c;
        priority if (np_c > 29'(Q24_MAX))      np_next = Q24_MAX;
        else if (np_c < 29'(Q24_MIN))          np_next = Q24_MIN;
        else                                   np_next = 24'(np_c);
        lap_o = backward_mode_reg ? ctx_reg[8].lap : '0;
    end

    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_cur_reg  <= s_tdata[23:0];
            s0_lane_reg <= col_cur[1:0];
            s0_dl_reg   <= col_cur[0];
            s0_col_reg  <= 12'(col_cur - COL_W'(2));
            s0_row_reg  <= 10'(row_cur);
            s0_last_reg <= frame_last;

            lx_reg     <= lx_next;
            lz_reg     <= lz_next;
            vel1_reg   <= win_reg[2][VEL_OFS + 32'(s0_dl_reg) * VEL_W +: VEL_W];
            ctx_reg[1] <= ctx1_next;
            for (int i = 2; i < 9; i++) ctx_reg[i] <= ctx_reg[i-1];

            px_reg  <= lx_reg * $signed({1'b0, inv_dx2_reg});
            pz_reg  <= lz_reg * $signed({1'b0, inv_dz2_reg});
            usq_reg <= usq_full[46:0];
            vsq_reg <= vel1_reg * vel1_reg;

            sum_reg       <= px_reg + pz_reg;
            pvd_lo_reg    <= vsq_reg * dt2_reg[23:0];
            pvd_hi_reg    <= vsq_reg * dt2_reg[47:24];
            ctx_reg[3].il <= ill_next;

            n_reg         <= rnd_c[63:34];
            neg4_reg      <= sum_reg[63];
            ctx_reg[4].vd <= 80'(pvd_lo_reg) + {pvd_hi_reg, 24'b0};

            q_reg    <= qprod_c[61:33];
            neg5_reg <= neg4_reg;

            ctx_reg[6].lap <= lap_next;

            pp0_reg <= ctx_reg[6].vd[26:0] * mag_c;
            pp1_reg <= ctx_reg[6].vd[53:27] * mag_c;
            pp2_reg <= ctx_reg[6].vd[79:54] * mag_c;

            total_reg <= 104'(pp0_reg) + (104'(pp1_reg) << 27) + (104'(pp2_reg) << 54)
                         + (104'(1) << 47);

            m_tdata_reg <= {2'b00, ctx_reg[8].row, ctx_reg[8].col, ctx_reg[8].il,
                            lap_o, np_next};
            m_tlast_reg <= ctx_reg[8].last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- rtl/awstep_checker.sv -----
// port-level checks for the wave stencil step, bound to the top level
`include "acoustic_wave_stencil_step_defines.svh"

module awstep_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [awstep_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                                m_tlast
);
    import awstep_pkg::*;

    // a pending result keeps its valid
    `AWS_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")

    // a pending result keeps its payload
    `AWS_ASSERT_NXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    // nothing comes out in the first cycle after reset
    `AWS_ASSERT_IMP(a_reset_quiet, aclk, aresetn, $past(!aresetn), !m_tvalid, "result right after reset")

    // only interior centres are ever emitted
    `AWS_ASSERT_IMP(a_interior, aclk, aresetn, m_tvalid, (m_tdata[OUT_ROW_LSB +: 10] >= 10'd2) && (m_tdata[OUT_COL_LSB +: 12] >= 12'd2), "border cell emitted")

endmodule

bind acoustic_wave_stencil_step awstep_checker u_awstep_checker (.*);

// ----- sim/tb.sv -----
// self-checking testbench for the acoustic wave stencil step
`timescale 1ns / 1ps

module tb;
    import awstep_pkg::*;

    localparam int LINE = 1024;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct {
        logic signed [23:0] new_prev;
        logic signed [23:0] lap;
        logic [31:0]        illum;
        logic [11:0]        col;
        logic [9:0]         row;
        logic               fend;
    } cell_result_t;

    typedef struct {
        logic [23:0] cur;
        logic [23:0] prv;
        logic [15:0] vel;
        logic [31:0] ill;
        logic        fs;
        logic        typed;
        logic [23:0] np_typed;
        logic [31:0] ill_typed;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    acoustic_wave_stencil_step dut (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    // predictor state
    logic signed [23:0] pr_field [4*LINE];
    logic signed [23:0] pr_prev [2*LINE];
    logic [15:0] pr_vel [2*LINE];
    logic [31:0] pr_ill [2*LINE];
    int unsigned pr_col = 0, pr_row = 0;
    logic        pr_bwd = 1'b0;
    logic [31:0] pr_dx = '0, pr_dz = '0;
    logic [47:0] pr_dt2 = '0;
    logic [10:0] pr_depth = 11'd1024;
    logic [12:0] pr_width = 13'd4096;

    cell_result_t stencil_q[$];
    int errors = 0;
    int stall_pct = 0;
    int idle_pct = 0;
    int hold_req = 0;
    int hold_cnt = 0;
    longint cycles = 0;

    function automatic logic signed [23:0] sat24(longint x);
        if (x > 64'sd8388607) return Q24_MAX;
        if (x < -64'sd8388608) return Q24_MIN;
        return 24'(x);
    endfunction

    function automatic logic signed [23:0] lap_round(longint x);
        longint unsigned ux, q;
        ux = (x < 0) ? longint'(0) - x : x;
        q = (ux + (64'd6 << 32)) / (64'd12 << 32);
        if (x < 0) return (q > 64'd8388608) ? Q24_MIN : 24'(-longint'(q));
        return (q > 64'd8388607) ? Q24_MAX : 24'(q);
    endfunction

    function automatic longint wave_term(logic [15:0] v, logic signed [23:0] lap);
        logic [127:0] p;
        logic [127:0] q;
        longint mag;
        mag = (lap < 0) ? -longint'(lap) : longint'(lap);
        p = 128'(pr_dt2) * 128'(v) * 128'(v) * 128'(mag) + (128'd1 << 47);
        q = p >> 48;
        if (q > 128'(TERM_LIM)) q = 128'(TERM_LIM);
        return (lap < 0) ? -longint'(q) : longint'(q);
    endfunction

    // advances the stencil position and returns 1 with the result when a centre is interior
    function automatic bit stencil_step(logic [23:0] cur_raw, logic [23:0] prv_raw,
                                        logic [15:0] vel, logic [31:0] ill, logic fs,
                                        output cell_result_t r);
        int unsigned depth, width, col, row, s0, d0, sc, sm, sp, ccol;
        longint u, cur, lx, lz, ub, term, sq, sum;
        logic signed [23:0] lap;
        logic [31:0] il;
        bit hit;
        depth = (pr_depth < 5) ? 5 : (pr_depth > LINE ? LINE : pr_depth);
        width = (pr_width < 5) ? 5 : (pr_width > 4096 ? 4096 : pr_width);
        cur = longint'($signed(cur_raw));
        hit = 0;
        if (fs) begin
            pr_col = 0;
            pr_row = 0;
        end
        col = pr_col;
        row = pr_row;
        if (row < LINE) begin
            s0 = (col % 4) * LINE;
            d0 = (col % 2) * LINE;
            if (col >= 4 && col < width && row >= 2 && row + 3 <= depth) begin
                sc = ((col + 2) % 4) * LINE;
                sm = ((col + 1) % 4) * LINE;
                sp = ((col + 3) % 4) * LINE;
                u = pr_field[sc + row];
                lx = -30 * u + 16 * (longint'(pr_field[sm + row]) + pr_field[sp + row])
                     - (longint'(pr_field[s0 + row]) + cur);
                lz = -30 * u + 16 * (longint'(pr_field[sc + row - 1]) + pr_field[sc + row + 1])
                     - (longint'(pr_field[sc + row - 2]) + pr_field[sc + row + 2]);
                lap = lap_round(lx * longint'({32'd0, pr_dx}) + lz * longint'({32'd0, pr_dz}));
                ub = pr_prev[d0 + row];
                il = pr_ill[d0 + row];
                term = wave_term(pr_vel[d0 + row], lap);
                r.new_prev = sat24(2 * u - ub + term);
                ccol = col - 2;
                if (pr_bwd) begin
                    sq = (u * u + 32768) >>> 16;
                    sum = longint'(il) + sq;
                    il = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(sum);
                end else begin
                    lap = '0;
                end
                r.lap = lap;
                r.illum = il;
                r.col = 12'(ccol);
                r.row = 10'(row);
                r.fend = (ccol + 3 == width && row + 3 == depth);
                hit = 1;
            end
            pr_field[s0 + row] = cur_raw;
            pr_prev[d0 + row] = prv_raw;
            pr_vel[d0 + row] = vel;
            pr_ill[d0 + row] = ill;
        end
        if (row + 1 >= depth) begin
            pr_row = 0;
            pr_col = (col + 1 >= width) ? 0 : col + 1;
        end else begin
            pr_row = row + 1;
            pr_col = (col >= width) ? 0 : col;
        end
        return hit;
    endfunction

    // receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (hold_req != 0 && hold_cnt == 0) begin
            hold_cnt <= hold_req;
            hold_req <= 0;
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cell_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (stencil_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transfer: %h", m_tdata);
            end else begin
                e = stencil_q.pop_front();
                if (m_tdata[23:0] !== e.new_prev || m_tdata[47:24] !== e.lap
                        || m_tdata[79:48] !== e.illum || m_tdata[91:80] !== e.col
                        || m_tdata[101:92] !== e.row || m_tlast !== e.fend) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp np=%h lap=%h ill=%h col=%0d row=%0d last=%b",
                                 e.new_prev, e.lap, e.illum, e.col, e.row, e.fend,
                                 "  got np=%h lap=%h ill=%h col=%0d row=%0d last=%b",
                                 m_tdata[23:0], m_tdata[47:24], m_tdata[79:48],
                                 m_tdata[91:80], m_tdata[101:92], m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout");
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_regs(logic bwd, logic [31:0] dx, logic [31:0] dz,
                              logic [47:0] dt2, logic [10:0] depth, logic [12:0] width);
        cfg_reg_t idx;
        logic [47:0] val;
        for (int i = 0; i < 6; i++) begin
            idx = cfg_reg_t'(i);
            case (idx)
                REG_BACKWARD_MODE: val = 48'(bwd);
                REG_INV_DX2:       val = 48'(dx);
                REG_INV_DZ2:       val = 48'(dz);
                REG_DT2:           val = dt2;
                REG_GRID_DEPTH:    val = 48'(depth);
                default:           val = 48'(width);
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        pr_bwd = bwd;
        pr_dx = dx;
        pr_dz = dz;
        pr_dt2 = dt2;
        pr_depth = depth;
        pr_width = width;
    endtask

    // sends one cell; a typed expectation replaces the predicted one
    task automatic send_cell(logic [23:0] cur, logic [23:0] prv, logic [15:0] vel,
                             logic [31:0] ill, logic fs, bit typed = 0,
                             cell_result_t typed_res = '{default: '0});
        cell_result_t r;
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ill, vel, prv, cur};
        s_tuser <= fs;
        do @(posedge aclk); while (!s_tready);
        if (stencil_step(cur, prv, vel, ill, fs, r))
            stencil_q.push_back(typed ? typed_res : r);
    endtask

    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (stencil_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_field();
        logic [23:0] v;
        v = 24'($urandom);
        case ($urandom_range(3))
            0: v = $signed(v) >>> $urandom_range(8, 20);
            1: v = $urandom_range(1) ? Q24_MAX : Q24_MIN;
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_random(int n, bit first_fs, int noise_pct);
        for (int i = 0; i < n; i++)
            send_cell(rand_field(), rand_field(), 16'($urandom), $urandom,
                      (i == 0 && first_fs) || ($urandom_range(999) < noise_pct));
    endtask

    dir_row_t dir_tab [25];
    cell_result_t tr;
    int depth_r, width_r, n_rand;

    initial begin
        // 5x5 frame: one centre at (2,2), emitted on the cell at column 4, row 2
        for (int i = 0; i < 25; i++) begin
            dir_tab[i] = '{cur: (i % 2) ? Q24_MIN : Q24_MAX, prv: (i % 3) ? 24'h000001 : 24'hFFFFFF,
                           vel: (i % 2) ? 16'hFFFF : 16'h0000, ill: (i % 2) ? 32'h0 : 32'hFFFFFFFF,
                           fs: (i == 0), typed: 0, np_typed: '0, ill_typed: '0};
        end
        dir_tab[12].cur = Q24_MAX;
        dir_tab[12].prv = Q24_MIN;
        dir_tab[12].ill = 32'hFFFFFFFF;
        dir_tab[22].typed = 1;
        dir_tab[22].np_typed = Q24_MAX;
        dir_tab[22].ill_typed = 32'hFFFFFFFF;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero coefficients, so new_prev = sat(2u - ub), illum passes
        write_regs(1'b0, '0, '0, '0, 11'd5, 13'd5);
        foreach (dir_tab[i]) begin
            tr = '{new_prev: dir_tab[i].np_typed, lap: '0, illum: dir_tab[i].ill_typed,
                   col: 12'd2, row: 10'd2, fend: 1'b1};
            send_cell(dir_tab[i].cur, dir_tab[i].prv, dir_tab[i].vel, dir_tab[i].ill,
                      dir_tab[i].fs, dir_tab[i].typed, tr);
        end
        // directed continues: wrap into a second frame without frame start
        send_random(25, 0, 0);
        drain_pipe();

        // clamped geometry from below, extreme coefficients, backward mode
        write_regs(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF, 11'd3, 13'd2);
        send_random(50, 1, 0);
        drain_pipe();

        // random phases with the four idling mixes
        n_rand = 0;
        for (int k = 0; n_rand < 1650; k++) begin
            case (k % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            depth_r = $urandom_range(5, 12);
            width_r = $urandom_range(5, 12);
            write_regs(1'(k), $urandom >> $urandom_range(31), $urandom >> $urandom_range(31),
                       {16'($urandom), 32'($urandom)} >> $urandom_range(47),
                       11'(depth_r), 13'(width_r));
            if (k == 1) hold_req = 400;
            send_random(2 * depth_r * width_r, 1, (k % 3 == 2) ? 15 : 0);
            n_rand += 2 * depth_r * width_r;
            drain_pipe();
        end

        // geometry shrinks in the middle of a frame
        idle_pct = 27;
        stall_pct = 27;
        write_regs(1'b1, $urandom, $urandom, 48'($urandom) << 8, 11'd9, 13'd12);
        send_random(40, 1, 0);
        drain_pipe();
        write_regs(1'b0, $urandom, $urandom, 48'($urandom) << 8, 11'd6, 13'd7);
        send_random(90, 0, 0);
        drain_pipe();

        // largest geometry in each direction, clamped from above
        idle_pct = 0;
        stall_pct = 10;
        write_regs(1'b1, $urandom, $urandom, {16'($urandom), 32'($urandom)}, 11'd2047, 13'd5);
        send_random(5 * 1024, 1, 0);
        drain_pipe();
        write_regs(1'b0, 32'd0, 32'd0, 48'd0, 11'd0, 13'd8191);
        send_random(5 * 4096 + 5, 1, 0);
        drain_pipe();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
